// ===== rtl/tbrt_pkg.sv =====
// shared types and constants for the token bucket rate table
// no dependencies
`timescale 1ns / 1ps

package tbrt_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int KEY_W       = 64;
	localparam int TIME_W      = 64;
	localparam int TOK_W       = 32;
	localparam int ENTRY_W     = KEY_W + TOK_W + TIME_W;
	localparam int DIV_W       = $clog2(TIME_W);

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// strobes from controller to datapath
	typedef struct packed {
		logic capture;
		logic scan;
		logic clr;
		logic load;
		logic div;
		logic mul;
		logic fin;
	} tbrt_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_done;
		logic is_clear;
		logic found;
		logic no_refill;
		logic div_done;
		logic out_busy;
	} tbrt_stat_t;

endpackage

// ===== rtl/token_bucket_rate_table.sv =====
// token bucket rate table: one item at a time, input stalled while an item is in flight
// check: the result follows a scan, a 64-step divide and one multiply; the divide is skipped
// when no refill applies, and divide and multiply are skipped when the table is full
// clear: no result; a stalled result holds off the next one
// reset clears all slot used bits at once, so no clearing pass is needed
// depends on tbrt_pkg, tbrt_ctrl, tbrt_dp
`timescale 1ns / 1ps

module token_bucket_rate_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [tbrt_pkg::KEY_W-1:0]  rule_id,
	input  logic [tbrt_pkg::TIME_W-1:0] now_ms,
	input  logic [tbrt_pkg::TOK_W-1:0]  burst,
	input  logic [tbrt_pkg::TOK_W-1:0]  refill_tokens,
	input  logic [tbrt_pkg::TOK_W-1:0]  interval_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       allowed,
	output logic                       table_full
);
	import tbrt_pkg::*;

	tbrt_cmd_t  ctl;
	tbrt_stat_t st;

	tbrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (st),
		.cmd      (ctl)
	);

	tbrt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_in        (cmd),
		.rule_id       (rule_id),
		.now_ms        (now_ms),
		.burst         (burst),
		.refill_tokens (refill_tokens),
		.interval_ms   (interval_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.allowed       (allowed),
		.table_full    (table_full),
		.cmd           (ctl),
		.stat          (st)
	);

endmodule

// ===== rtl/tbrt_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tbrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tbrt_ctrl.sv =====
// controller state machine for the token bucket rate table
// depends on tbrt_pkg
`timescale 1ns / 1ps

module tbrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tbrt_pkg::tbrt_stat_t stat,
	output tbrt_pkg::tbrt_cmd_t  cmd
);
	import tbrt_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_CLR  = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	// next state and strobes
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					if (stat.is_clear) begin
						state_d = ST_CLR;
					end else if (stat.found) begin
						state_d = ST_LOAD;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_CLR: begin
				cmd.clr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = stat.no_refill ? ST_MUL : ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/tbrt_dp.sv =====
// datapath: slot table, scan compare, serial divider, refill and output register
// depends on tbrt_pkg and tbrt_ram
`timescale 1ns / 1ps

module tbrt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_in,
	input  logic [tbrt_pkg::KEY_W-1:0]  rule_id,
	input  logic [tbrt_pkg::TIME_W-1:0] now_ms,
	input  logic [tbrt_pkg::TOK_W-1:0]  burst,
	input  logic [tbrt_pkg::TOK_W-1:0]  refill_tokens,
	input  logic [tbrt_pkg::TOK_W-1:0]  interval_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       allowed,
	output logic                       table_full,
	input  tbrt_pkg::tbrt_cmd_t         cmd,
	output tbrt_pkg::tbrt_stat_t        stat
);
	import tbrt_pkg::*;

	// captured item
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;
	logic [TOK_W-1:0]  burst_q;
	logic [TOK_W-1:0]  per_q;
	logic [TOK_W-1:0]  ival_q;

	// table state
	logic [TABLE_SLOTS-1:0] used_q;
	logic [ENTRY_W-1:0]     rdata;
	logic                   we;
	logic [ENTRY_W-1:0]     wdata;

	// scan
	logic [CNT_W-1:0]  addr_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              match_q;
	logic              free_q;
	logic [SLOT_W-1:0] pick_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic [TOK_W-1:0]  tok_q;
	logic [TIME_W-1:0] time_q;

	// refill arithmetic
	logic [TIME_W-1:0] quo_q;
	logic [TOK_W:0]    rem_q;
	logic [DIV_W-1:0]  div_cnt_q;
	logic              norefill_q;
	logic [2*TOK_W-1:0] prod_q;

	logic [TOK_W:0]    rem_sh;
	logic              rem_ge;
	logic [TIME_W-1:0] base_time;
	logic              do_refill;
	logic              n_zero;
	logic              n_high;
	logic [2*TOK_W:0]  sum;
	logic [TOK_W-1:0]  new_tok;
	logic [TIME_W-1:0] new_time;
	logic              has_tok;

	logic              out_valid_q;
	logic              allowed_q;
	logic              full_q;

	tbrt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (pick_q),
		.wdata (wdata),
		.raddr (addr_q[SLOT_W-1:0]),
		.rdata (rdata)
	);

	// status back to the controller
	assign stat.scan_done = (addr_q == CNT_W'(TABLE_SLOTS)) && !rd_vld_s1;
	assign stat.is_clear  = (op_q == CMD_CLEAR);
	assign stat.found     = match_q || free_q;
	assign stat.no_refill = !do_refill;
	assign stat.div_done  = (div_cnt_q == DIV_W'(TIME_W - 1));
	assign stat.out_busy  = out_valid_q && out_stall;

	// one restoring division step
	assign rem_sh = {rem_q[TOK_W-1:0], quo_q[TIME_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, ival_q});

	assign base_time = match_q ? time_q : now_q;
	assign do_refill = (ival_q != '0) && (now_q > base_time);

	// refill result and token consume
	assign n_zero  = (quo_q == '0);
	assign n_high  = (quo_q[TIME_W-1:TOK_W] != '0) && (per_q != '0);
	assign sum     = {1'b0, prod_q} + {{(TOK_W+1){1'b0}}, tok_q};
	always_comb begin
		if (n_zero) begin
			new_tok  = tok_q;
			new_time = time_q;
		end else begin
			new_tok  = (n_high || (sum > {{(TOK_W+1){1'b0}}, burst_q})) ?
				burst_q : sum[TOK_W-1:0];
			new_time = now_q - {{(TIME_W-TOK_W){1'b0}}, rem_q[TOK_W-1:0]};
		end
	end
	assign has_tok = (new_tok != '0);
	assign we      = cmd.fin && stat.found;
	assign wdata   = {key_q, has_tok ? (new_tok - 1'b1) : new_tok, new_time};

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= cmd_in;
			key_q   <= rule_id;
			now_q   <= now_ms;
			burst_q <= burst;
			per_q   <= refill_tokens;
			ival_q  <= interval_ms;
		end
	end

	// scan address and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
		end else if (cmd.capture) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
		end else if (cmd.scan) begin
			if (addr_q != CNT_W'(TABLE_SLOTS)) begin
				rd_vld_s1 <= 1'b1;
				addr_q    <= addr_q + 1'b1;
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			if (rd_vld_s1) begin
				if (used_q[idx_s1] && (rdata[ENTRY_W-1 -: KEY_W] == key_q)) begin
					match_q <= 1'b1;
				end else if (!used_q[idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			idx_s1 <= addr_q[SLOT_W-1:0];
			if (rd_vld_s1) begin
				if (used_q[idx_s1] && (rdata[ENTRY_W-1 -: KEY_W] == key_q)) begin
					pick_q <= idx_s1;
					tok_q  <= rdata[TIME_W +: TOK_W];
					time_q <= rdata[TIME_W-1:0];
				end else if (!used_q[idx_s1] && !free_q) begin
					free_idx_q <= idx_s1;
				end
			end
		end else if (cmd.load) begin
			if (!match_q) begin
				pick_q <= free_idx_q;
				tok_q  <= burst_q;
				time_q <= now_q;
			end
		end
	end

	// slot used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clr && match_q) begin
			used_q[pick_q] <= 1'b0;
		end else if (we) begin
			used_q[pick_q] <= 1'b1;
		end
	end

	// elapsed time divider and multiply
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q      <= do_refill ? (now_q - base_time) : '0;
			rem_q      <= '0;
			div_cnt_q  <= '0;
			norefill_q <= !do_refill;
		end else if (cmd.div) begin
			quo_q     <= {quo_q[TIME_W-2:0], rem_ge};
			rem_q     <= rem_ge ? (rem_sh - {1'b0, ival_q}) : rem_sh;
			div_cnt_q <= div_cnt_q + 1'b1;
		end else if (cmd.mul) begin
			prod_q <= norefill_q ? '0 : (quo_q[TOK_W-1:0] * per_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			allowed_q <= stat.found ? has_tok : 1'b1;
			full_q    <= !stat.found;
		end
	end

	assign out_valid  = out_valid_q;
	assign allowed    = allowed_q;
	assign table_full = full_q;

endmodule

// ===== rtl/tbrt_checker.sv =====
// port level checks for the token bucket rate table, bound to the top level
// depends on token_bucket_rate_table
`timescale 1ns / 1ps

module tbrt_port_checks (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic allowed,
	input logic table_full
);

	// one item in flight: a transfer in makes the input busy
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transfer");

	// with the input idle no result is being produced, so a result transfer empties the output
	a_no_back_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("result appeared without new work");

	// fail-open always allows
	a_full_allows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> allowed)
		else $error("table full result refused");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(allowed) && $stable(table_full))
		else $error("stalled result changed");

endmodule

bind token_bucket_rate_table tbrt_port_checks u_tbrt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.allowed    (allowed),
	.table_full (table_full)
);

// ===== tb/tbrt_checker.sv =====
// transfer monitor, bucket table predictor and result scoreboard for token_bucket_rate_table
// depends on tbrt_pkg
`timescale 1ns / 1ps

module tbrt_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        cmd,
	input  logic [tbrt_pkg::KEY_W-1:0]  rule_id,
	input  logic [tbrt_pkg::TIME_W-1:0] now_ms,
	input  logic [tbrt_pkg::TOK_W-1:0]  burst,
	input  logic [tbrt_pkg::TOK_W-1:0]  refill_tokens,
	input  logic [tbrt_pkg::TOK_W-1:0]  interval_ms,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        allowed,
	input  logic                        table_full,
	output int                          errors,
	output int                          pending,
	output int                          n_checks,
	output int                          n_refused,
	output int                          n_full
);
	import tbrt_pkg::*;

	typedef struct packed {
		logic allowed;
		logic full;
	} verdict_t;

	// shadow copy of the bucket table
	logic              bkt_used [TABLE_SLOTS];
	logic [KEY_W-1:0]  bkt_key  [TABLE_SLOTS];
	logic [TOK_W-1:0]  bkt_tok  [TABLE_SLOTS];
	logic [TIME_W-1:0] bkt_time [TABLE_SLOTS];

	verdict_t verdicts_due[$];

	// top up slot s by whole elapsed intervals, saturating, capped at burst
	task automatic top_up(input int s, input logic [63:0] t, input logic [31:0] cap,
			input logic [31:0] per, input logic [31:0] ival);
		logic [63:0]  span;
		logic [63:0]  n;
		logic [127:0] prod;
		logic [63:0]  add;
		logic [64:0]  sum;
		logic [63:0]  total;
		if (ival == 0 || t <= bkt_time[s])
			return;
		span = t - bkt_time[s];
		n    = span / {32'd0, ival};
		if (n == 0)
			return;
		prod  = {64'd0, n} * {96'd0, per};
		add   = (prod[127:64] != 0) ? '1 : prod[63:0];
		sum   = {33'd0, bkt_tok[s]} + {1'b0, add};
		total = sum[64] ? '1 : sum[63:0];
		bkt_tok[s]  = (total > {32'd0, cap}) ? cap : total[31:0];
		bkt_time[s] = bkt_time[s] + n * {32'd0, ival};
	endtask

	// apply one accepted request to the shadow table, queue its verdict if any
	task automatic apply_request();
		int       pick;
		verdict_t v;
		pick = -1;
		if (cmd == CMD_CLEAR) begin
			for (int s = 0; s < TABLE_SLOTS; s++) begin
				if (bkt_used[s] && bkt_key[s] == rule_id) begin
					bkt_used[s] = 1'b0;
					bkt_key[s]  = '0;
					bkt_tok[s]  = '0;
					bkt_time[s] = '0;
					break;
				end
			end
			return;
		end
		// matching slot wins, otherwise lowest free slot
		for (int s = 0; s < TABLE_SLOTS; s++) begin
			if (bkt_used[s] && bkt_key[s] == rule_id) begin
				pick = s;
				break;
			end
			if (!bkt_used[s] && pick < 0)
				pick = s;
		end
		n_checks++;
		if (pick < 0) begin
			v.allowed = 1'b1;
			v.full    = 1'b1;
			n_full++;
		end else begin
			if (!bkt_used[pick]) begin
				bkt_used[pick] = 1'b1;
				bkt_key[pick]  = rule_id;
				bkt_tok[pick]  = burst;
				bkt_time[pick] = now_ms;
			end
			top_up(pick, now_ms, burst, refill_tokens, interval_ms);
			v.full = 1'b0;
			if (bkt_tok[pick] != 0) begin
				bkt_tok[pick]--;
				v.allowed = 1'b1;
			end else begin
				v.allowed = 1'b0;
				n_refused++;
			end
		end
		verdicts_due.push_back(v);
	endtask

	// watch both channels on the clock edge
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			for (int s = 0; s < TABLE_SLOTS; s++) begin
				bkt_used[s] = 1'b0;
				bkt_key[s]  = '0;
				bkt_tok[s]  = '0;
				bkt_time[s] = '0;
			end
			verdicts_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer: allowed=%0b table_full=%0b",
						$time, allowed, table_full);
				end else begin
					want = verdicts_due.pop_front();
					if (allowed !== want.allowed) begin
						errors++;
						$display("%0t: allowed mismatch: expected %0b, got %0b",
							$time, want.allowed, allowed);
					end
					if (table_full !== want.full) begin
						errors++;
						$display("%0t: table_full mismatch: expected %0b, got %0b",
							$time, want.full, table_full);
					end
				end
			end
			if (in_valid && !in_stall)
				apply_request();
		end
		pending = verdicts_due.size();
	end

	initial begin
		errors    = 0;
		pending   = 0;
		n_checks  = 0;
		n_refused = 0;
		n_full    = 0;
	end

endmodule

// ===== tb/tb_token_bucket_rate_table.sv =====
// testbench top for token_bucket_rate_table: clock, reset, request stimulus, verdict
// depends on tbrt_pkg, token_bucket_rate_table and tbrt_checker
`timescale 1ns / 1ps

module tb_token_bucket_rate_table;
	import tbrt_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic [KEY_W-1:0]   rule_id;
	logic [TIME_W-1:0]  now_ms;
	logic [TOK_W-1:0]   burst;
	logic [TOK_W-1:0]   refill_tokens;
	logic [TOK_W-1:0]   interval_ms;
	logic               out_valid;
	logic               out_stall;
	logic               allowed;
	logic               table_full;

	int errors, pending, n_checks, n_refused, n_full;
	int send_idle_pct, recv_stall_pct;
	bit hold_req;
	logic [63:0] key_pool [96];
	logic [63:0] clock_ms;

	token_bucket_rate_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .rule_id(rule_id), .now_ms(now_ms), .burst(burst),
		.refill_tokens(refill_tokens), .interval_ms(interval_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.allowed(allowed), .table_full(table_full)
	);

	tbrt_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .rule_id(rule_id), .now_ms(now_ms), .burst(burst),
		.refill_tokens(refill_tokens), .interval_ms(interval_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.allowed(allowed), .table_full(table_full),
		.errors(errors), .pending(pending), .n_checks(n_checks),
		.n_refused(n_refused), .n_full(n_full)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// receiver stalls; a requested hold-off keeps stall high for a long stretch
	always @(posedge clk) begin
		if (hold_req) begin
			out_stall <= 1'b1;
			repeat (3000) @(posedge clk);
			hold_req = 1'b0;
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// offer one request, with random idle cycles first; valid stays high between items
	task automatic send_req(input logic c, input logic [63:0] k, input logic [63:0] t,
			input logic [31:0] b, input logic [31:0] per, input logic [31:0] iv);
		bit ok;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		rule_id       <= k;
		now_ms        <= t;
		burst         <= b;
		refill_tokens <= per;
		interval_ms   <= iv;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
	endtask

	// one random request: mostly checks on a pool of keys with a moving clock
	task automatic random_req(input int pool_top, input int clear_pct);
		logic        c;
		logic [31:0] b, per, iv;
		int          r;
		c = ($urandom_range(99) < clear_pct) ? CMD_CLEAR : CMD_CHECK;
		r = $urandom_range(99);
		if (r < 2)
			clock_ms = {$urandom, $urandom};
		else if (r < 5)
			clock_ms = clock_ms - $urandom_range(40);
		else if (r < 10)
			clock_ms = clock_ms + ({$urandom, $urandom} >> $urandom_range(63));
		else
			clock_ms = clock_ms + $urandom_range(30);
		b   = ($urandom_range(99) < 80) ? $urandom_range(5) : $urandom;
		per = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom;
		r   = $urandom_range(99);
		iv  = (r < 10) ? 32'd0 : (r < 80) ? $urandom_range(20, 1) : $urandom;
		send_req(c, key_pool[$urandom_range(pool_top)], clock_ms, b, per, iv);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		out_stall      = 1'b0;
		cmd            = CMD_CHECK;
		rule_id        = '0;
		now_ms         = '0;
		burst          = '0;
		refill_tokens  = '0;
		interval_ms    = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		clock_ms       = '0;
		key_pool[0]    = '0;
		key_pool[1]    = '1;
		for (int i = 2; i < 96; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: new bucket, drain, refill, time going back, no refill, lowered burst
		send_req(CMD_CHECK, 64'h5, 64'd0, 32'd2, 32'd1, 32'd10);
		send_req(CMD_CHECK, 64'h5, 64'd0, 32'd2, 32'd1, 32'd10);
		send_req(CMD_CHECK, 64'h5, 64'd9, 32'd2, 32'd1, 32'd10);
		send_req(CMD_CHECK, 64'h5, 64'd25, 32'd2, 32'd1, 32'd10);
		send_req(CMD_CHECK, 64'h5, 64'd3, 32'd2, 32'd1, 32'd10);
		send_req(CMD_CHECK, 64'h5, 64'd1000, 32'd2, 32'd5, 32'd0);
		send_req(CMD_CHECK, 64'h6, 64'd40, 32'd9, 32'd0, 32'd4);
		send_req(CMD_CHECK, 64'h6, 64'd41, 32'd1, 32'd0, 32'd0);
		send_req(CMD_CHECK, 64'h6, 64'd100, 32'd1, 32'd3, 32'd4);
		// clear of an unknown id, then a clear that frees a slot for a fresh bucket
		send_req(CMD_CLEAR, 64'hdead_beef_0000_0001, 64'd100, 32'd0, 32'd0, 32'd0);
		send_req(CMD_CLEAR, 64'h5, 64'd100, 32'd0, 32'd0, 32'd0);
		send_req(CMD_CHECK, 64'h5, 64'd100, 32'd1, 32'd0, 32'd0);
		send_req(CMD_CHECK, 64'h5, 64'd100, 32'd1, 32'd0, 32'd0);
		// extreme keys and sizes, zero burst, saturating refill
		send_req(CMD_CHECK, '0, 64'd0, 32'd0, 32'd0, 32'd0);
		send_req(CMD_CHECK, '1, 64'd0, '1, '1, 32'd1);
		send_req(CMD_CHECK, '1, 64'd0, '1, '1, 32'd1);
		send_req(CMD_CHECK, '1, '1, '1, '1, 32'd1);
		send_req(CMD_CHECK, '1, '1, '1, '1, '1);
		send_req(CMD_CHECK, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'd3,
			32'h8000_0000, 32'h8000_0000);
		send_req(CMD_CHECK, 64'h8000_0000_0000_0000, '1, 32'd3, 32'h8000_0000,
			32'h8000_0000);
		send_req(CMD_CLEAR, '1, '1, '1, '1, '1);
		send_req(CMD_CLEAR, '0, '1, '1, '1, '1);

		// random phases: no idling, sender idle, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 27 : 0;
			recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 27 : 0;
			if (ph == 2)
				hold_req = 1'b1;
			for (int i = 0; i < 150; i++)
				random_req((ph < 2) ? 40 : 95, (ph < 2) ? 10 : 3);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d checks (%0d refused, %0d table full) plus clears,",
			n_checks, n_refused, n_full);
		$display("with sender gaps, receiver stalls and one long receiver hold-off");
		if (pending != 0)
			$display("%0t: %0d results never arrived", $time, pending);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("timeout");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tbrt_pkg.sv
rtl/tbrt_ram.sv
rtl/tbrt_ctrl.sv
rtl/tbrt_dp.sv
rtl/token_bucket_rate_table.sv
rtl/tbrt_checker.sv
tb/tbrt_checker.sv
tb/tb_token_bucket_rate_table.sv
